// ===== rtl/abtt_pkg.sv =====
// Package for the array binary tree traversal block.
// Holds the request/result types, opcode and order codes, and the control ROM.
// No dependencies.
package abtt_pkg;

    localparam int NODE_W        = 4;
    localparam int VAL_W         = 32;
    localparam int DEFAULT_NODES = 16;
    localparam int MAX_STORE     = 1 << NODE_W;

    // request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WALK = 1'b1;

    // walk orders; ORD_NONE never matches a valid order
    localparam logic [1:0] ORD_PRE  = 2'd0;
    localparam logic [1:0] ORD_IN   = 2'd1;
    localparam logic [1:0] ORD_POST = 2'd2;
    localparam logic [1:0] ORD_NONE = 2'd3;

    // sequencer steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] ST_LEFT  = 3'd1;
    localparam logic [STEP_W-1:0] ST_RIGHT = 3'd2;
    localparam logic [STEP_W-1:0] ST_UP    = 3'd3;
    localparam logic [STEP_W-1:0] ST_FLUSH = 3'd4;

    // datapath actions
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_LEFT  = 3'd1;
    localparam logic [2:0] ACT_RIGHT = 3'd2;
    localparam logic [2:0] ACT_CLIMB = 3'd3;
    localparam logic [2:0] ACT_FLUSH = 3'd4;

    typedef struct packed {
        logic                    opcode;
        logic [NODE_W-1:0]       node_index;
        logic signed [VAL_W-1:0] node_value;
        logic [1:0]              walk_order;
    } abtt_req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] visited_value;
        logic                    last_of_walk;
    } abtt_rsp_t;

    // hit: child present / climb reached the start node
    // miss: child absent / climb from a left child
    // alt: climb from a right child
    typedef struct packed {
        logic [1:0]        emit_ord;
        logic [2:0]        act;
        logic [STEP_W-1:0] nxt_hit;
        logic [STEP_W-1:0] nxt_miss;
        logic [STEP_W-1:0] nxt_alt;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uw;
        unique case (step)
            ST_LEFT:  uw = '{ORD_PRE,  ACT_LEFT,  ST_LEFT,  ST_RIGHT, ST_RIGHT};
            ST_RIGHT: uw = '{ORD_IN,   ACT_RIGHT, ST_LEFT,  ST_UP,    ST_UP};
            ST_UP:    uw = '{ORD_POST, ACT_CLIMB, ST_FLUSH, ST_RIGHT, ST_UP};
            ST_FLUSH: uw = '{ORD_NONE, ACT_FLUSH, ST_IDLE,  ST_IDLE,  ST_IDLE};
            default:  uw = '{ORD_NONE, ACT_NONE,  ST_IDLE,  ST_IDLE,  ST_IDLE};
        endcase
        return uw;
    endfunction

endpackage

// ===== rtl/array_binary_tree_traversal.sv =====
// Top level of the array binary tree traversal block: node store, step sequencer
// driven by the control ROM, and result register. Depends on abtt_pkg.
//
// Channel  | Direction | Handshake                         | Payload
// ---------+-----------+-----------------------------------+-----------
// request  | in        | start high while busy low         | req
// result   | out       | result_valid high for one cycle   | result
//
// A load request gives no result. A walk request passes through the three
// sequencer steps (left, right, up) on each visited node, then a flush step.
// Each result is held back one visit so the final one can carry last_of_walk.
// Reset clears the node store and the sequencer; the receiver cannot stall,
// so results never wait.
module array_binary_tree_traversal
    import abtt_pkg::*;
#(
    parameter int NODES = DEFAULT_NODES
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  abtt_req_t req,
    output logic      busy,
    output logic      result_valid,
    output abtt_rsp_t result
);

    localparam int DEPTH = (NODES < MAX_STORE) ? NODES : MAX_STORE;
    localparam int AW    = $clog2(DEPTH);

    logic signed [VAL_W-1:0] store_reg [DEPTH];

    logic [STEP_W-1:0]       step_reg, step_next;
    logic [NODE_W-1:0]       cur_reg, cur_next;
    logic [NODE_W-1:0]       root_reg, root_next;
    logic [1:0]              order_reg, order_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic signed [VAL_W-1:0] pend_val_reg, pend_val_next;
    logic                    result_valid_reg, result_valid_next;
    abtt_rsp_t               result_reg, result_next;

    ucode_t                  uw;
    logic                    accept;
    logic                    do_load;
    logic                    walk_ok;
    logic [NODE_W:0]         probe;
    logic                    probe_hit;
    logic signed [VAL_W-1:0] cur_val;
    logic                    emit;

    assign uw      = ucode_rom(step_reg);
    assign busy    = (step_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign do_load = accept && (req.opcode == OP_LOAD) && (req.node_index != '0)
                     && (32'(req.node_index) < DEPTH);
    assign walk_ok = (req.node_index != '0) && (32'(req.node_index) < DEPTH)
                     && (req.walk_order != ORD_NONE);

    // child index: cur*2 for left, cur*2+1 for right
    assign probe     = {cur_reg, (uw.act == ACT_RIGHT)};
    assign probe_hit = (32'(probe) < DEPTH) && (store_reg[probe[AW-1:0]] != '0);
    assign cur_val   = store_reg[cur_reg[AW-1:0]];
    assign emit      = (uw.emit_ord == order_reg);

    always_comb
    begin
        step_next         = step_reg;
        cur_next          = cur_reg;
        root_next         = root_reg;
        order_next        = order_reg;
        pend_valid_next   = pend_valid_reg;
        pend_val_next     = pend_val_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        if (accept && (req.opcode == OP_WALK) && walk_ok)
        begin
            cur_next   = req.node_index;
            root_next  = req.node_index;
            order_next = req.walk_order;
            step_next  = ST_LEFT;
        end

        // hold the newest visit back; release the one before it
        if (emit)
        begin
            result_valid_next = pend_valid_reg;
            result_next       = '{pend_val_reg, 1'b0};
            pend_valid_next   = 1'b1;
            pend_val_next     = cur_val;
        end

        case (uw.act) inside
            ACT_LEFT, ACT_RIGHT:
            begin
                if (probe_hit)
                begin
                    cur_next  = probe[NODE_W-1:0];
                    step_next = uw.nxt_hit;
                end
                else
                begin
                    step_next = uw.nxt_miss;
                end
            end
            ACT_CLIMB:
            begin
                if (cur_reg == root_reg)
                begin
                    step_next = uw.nxt_hit;
                end
                else
                begin
                    cur_next  = {1'b0, cur_reg[NODE_W-1:1]};
                    step_next = cur_reg[0] ? uw.nxt_alt : uw.nxt_miss;
                end
            end
            ACT_FLUSH:
            begin
                result_valid_next = pend_valid_reg;
                result_next       = '{pend_val_reg, 1'b1};
                pend_valid_next   = 1'b0;
                step_next         = uw.nxt_hit;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= ST_IDLE;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        root_reg     <= root_next;
        order_reg    <= order_next;
        pend_val_reg <= pend_val_next;
        result_reg   <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (do_load)
        begin
            store_reg[req.node_index[AW-1:0]] <= req.node_value;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
